>>> rtl/rlol_pkg.sv
// Shared types and constants of the ring log offset lookup block.
package rlol_pkg;

	localparam int unsigned DEPTH_DEF = 10;
	localparam int unsigned HANDLE_W = 32;
	localparam int unsigned SIZE_W = 16;
	localparam int unsigned OFFSET_W = 20;
	localparam int unsigned SLOT_W = 4;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_FIND = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [SIZE_W-1:0]   size;
	} entry_t;

	typedef struct packed {
		logic                found;
		logic [HANDLE_W-1:0] handle;
		logic [SLOT_W-1:0]   slot;
		logic [SIZE_W-1:0]   byte_in_entry;
		logic                overwrote;
	} result_t;

endpackage

>>> rtl/rlol_if.sv
// Item channel interfaces of the ring log offset lookup block.
interface rlol_in_if;
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic [rlol_pkg::HANDLE_W-1:0] entry_handle;
	logic [rlol_pkg::SIZE_W-1:0]   entry_size;
	logic [rlol_pkg::OFFSET_W-1:0] byte_offset;

	modport source(output valid, opcode, entry_handle, entry_size, byte_offset, input ready);
	modport sink(input valid, opcode, entry_handle, entry_size, byte_offset, output ready);
endinterface

interface rlol_out_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [rlol_pkg::HANDLE_W-1:0] found_handle;
	logic [rlol_pkg::SLOT_W-1:0]   found_slot;
	logic [rlol_pkg::SIZE_W-1:0]   byte_in_entry;
	logic                          overwrote;

	modport source(output valid, found, found_handle, found_slot, byte_in_entry, overwrote,
		input ready);
	modport sink(input valid, found, found_handle, found_slot, byte_in_entry, overwrote,
		output ready);
endinterface

>>> rtl/rlol_slot_ram.sv
// Slot memory holding handle and size per ring slot, with per-slot valid bits.
module rlol_slot_ram #(
	parameter int unsigned DEPTH = rlol_pkg::DEPTH_DEF,
	parameter int unsigned IDX_W = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_addr,
	input  rlol_pkg::entry_t     wr_data,
	input  logic [IDX_W-1:0]     rd_addr,
	output rlol_pkg::entry_t     rd_data
);

	rlol_pkg::entry_t mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	rlol_pkg::entry_t rd_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// A slot never written reads as the reset value of zero.
	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

>>> rtl/ring_log_offset_lookup_core.sv
// Ring log of DEPTH slots: add stores a handle and byte size in the next slot, overwriting the
// oldest entry once the ring is full; find walks the stored entries from oldest to newest and
// returns the entry holding a byte offset into their concatenation. The slots live in one
// synchronous memory that a find reads one slot per cycle: a find is accepted, reads the stored
// slots in turn from the oldest until one holds the offset, and then holds its result; an add
// writes its slot when accepted and then holds its result. One item is worked on at a time; a
// finished result waits in an output register while the next item is taken in.
module ring_log_offset_lookup_core #(
	parameter int unsigned DEPTH = rlol_pkg::DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	rlol_in_if.sink    req,
	rlol_out_if.source rsp
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W:0] DEPTH_CNT = (CNT_W + 1)'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_HOLD = 3'b100
	} state_t;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	state_t                        state_q;
	logic [IDX_W-1:0]              write_q;
	logic [IDX_W-1:0]              read_q;
	logic                          full_q;
	logic [IDX_W-1:0]              idx_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [rlol_pkg::OFFSET_W-1:0] rem_q;
	rlol_pkg::result_t             res_q;
	rlol_pkg::result_t             out_q;
	logic                          out_valid_q;

	logic                          accept;
	logic                          is_add;
	logic                          out_free;
	logic [CNT_W:0]                cnt_start;
	logic [IDX_W-1:0]              rd_addr;
	rlol_pkg::entry_t              rd_data;
	rlol_pkg::entry_t              wr_data;
	logic                          hit;
	logic [IDX_W-1:0]              write_next;

	assign req.ready = (state_q == S_IDLE);
	assign accept = req.valid && req.ready;
	assign is_add = (req.opcode == rlol_pkg::OP_ADD);
	assign out_free = !out_valid_q || rsp.ready;
	assign write_next = next_idx(write_q);
	assign rd_addr = (state_q == S_IDLE) ? read_q : next_idx(idx_q);
	assign hit = {{(rlol_pkg::OFFSET_W - rlol_pkg::SIZE_W){1'b0}}, rd_data.size} > rem_q;
	assign wr_data = '{handle: req.entry_handle, size: req.entry_size};

	always_comb begin
		if (full_q) begin
			cnt_start = DEPTH_CNT;
		end else if (write_q >= read_q) begin
			cnt_start = (CNT_W + 1)'(write_q) - (CNT_W + 1)'(read_q);
		end else begin
			cnt_start = (CNT_W + 1)'(write_q) + DEPTH_CNT - (CNT_W + 1)'(read_q);
		end
	end

	rlol_slot_ram #(
		.DEPTH(DEPTH),
		.IDX_W(IDX_W)
	) u_slot_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept && is_add),
		.wr_addr(write_q),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			write_q <= '0;
			read_q <= '0;
			full_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_add) begin
							write_q <= write_next;
							if (full_q) begin
								read_q <= write_next;
							end else if (write_next == read_q) begin
								full_q <= 1'b1;
							end
							state_q <= S_HOLD;
						end else if (cnt_start == '0) begin
							state_q <= S_HOLD;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (hit || cnt_q == CNT_W'(1)) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_q <= '{found: 1'b0, handle: '0, slot: '0, byte_in_entry: '0,
						overwrote: is_add && full_q};
					rem_q <= req.byte_offset;
					cnt_q <= CNT_W'(cnt_start);
					idx_q <= read_q;
				end
			end
			S_WALK: begin
				if (hit) begin
					res_q <= '{found: 1'b1, handle: rd_data.handle,
						slot: rlol_pkg::SLOT_W'(idx_q),
						byte_in_entry: rem_q[rlol_pkg::SIZE_W-1:0], overwrote: 1'b0};
				end else begin
					rem_q <= rem_q - {{(rlol_pkg::OFFSET_W - rlol_pkg::SIZE_W){1'b0}},
						rd_data.size};
					cnt_q <= cnt_q - 1'b1;
					idx_q <= rd_addr;
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_HOLD && out_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_HOLD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.found = out_q.found;
	assign rsp.found_handle = out_q.handle;
	assign rsp.found_slot = out_q.slot;
	assign rsp.byte_in_entry = out_q.byte_in_entry;
	assign rsp.overwrote = out_q.overwrote;

	// Once full, the oldest entry is always the one about to be overwritten.
	a_full_indices: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> read_q == write_q)
		else $error("read index differs from write index on a full ring");

	a_fill_origin: assert property (@(posedge clk) disable iff (!arst_n)
		!full_q |-> read_q == '0)
		else $error("read index moved before the ring was full");

	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> cnt_q != '0)
		else $error("slot walk running with no slots left");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> !rsp.overwrote)
		else $error("result reports both a find hit and an overwrite");

endmodule

>>> sim/ring_log_offset_lookup_core_test.sv
// Self-checking testbench for the ring log offset lookup core.
module ring_log_offset_lookup_core_test;

	localparam int unsigned DEPTH = rlol_pkg::DEPTH_DEF;
	localparam int unsigned HANDLE_W = rlol_pkg::HANDLE_W;
	localparam int unsigned SIZE_W = rlol_pkg::SIZE_W;
	localparam int unsigned OFFSET_W = rlol_pkg::OFFSET_W;
	localparam int unsigned SLOT_W = rlol_pkg::SLOT_W;
	localparam int unsigned RANDOM_ITEMS = 1900;
	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned STEP_COUNT = 24;

	typedef rlol_pkg::result_t result_t;
	typedef rlol_pkg::opcode_t opcode_t;

	localparam result_t EMPTY_RESULT = '0;
	localparam result_t OVERWRITE_RESULT = '{found: 1'b0, handle: '0, slot: '0,
		byte_in_entry: '0, overwrote: 1'b1};

	typedef struct packed {
		opcode_t             op;
		logic [HANDLE_W-1:0] handle;
		logic [SIZE_W-1:0]   size;
		logic [OFFSET_W-1:0] offset;
		logic                typed;
		result_t             want;
	} step_t;

	logic clk;
	logic arst_n;

	rlol_in_if  req_if();
	rlol_out_if rsp_if();

	ring_log_offset_lookup_core #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	logic [SIZE_W-1:0]   ring_sizes [DEPTH];
	logic [HANDLE_W-1:0] ring_handles [DEPTH];
	int unsigned         ring_wr;
	int unsigned         ring_rd;
	logic                ring_full;

	result_t     expected_q [$];
	int unsigned fail_count;
	int unsigned add_count;
	int unsigned find_count;
	int unsigned hit_count;
	int unsigned overwrite_count;
	int unsigned idle_cycles;
	logic        snd_burst;
	logic        rcv_burst;

	step_t steps [STEP_COUNT] = '{
		'{rlol_pkg::OP_FIND, 32'h0000_0000, 16'h0000, 20'h00000, 1'b1, EMPTY_RESULT},
		'{rlol_pkg::OP_FIND, 32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF, 1'b1, EMPTY_RESULT},
		'{rlol_pkg::OP_ADD,  32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF, 1'b1, EMPTY_RESULT},
		'{rlol_pkg::OP_ADD,  32'h0000_0000, 16'h0000, 20'h00000, 1'b1, EMPTY_RESULT},
		'{rlol_pkg::OP_FIND, 32'h0000_0000, 16'h0000, 20'h00000, 1'b1,
			'{found: 1'b1, handle: 32'hFFFF_FFFF, slot: 4'd0, byte_in_entry: 16'h0000,
			overwrote: 1'b0}},
		'{rlol_pkg::OP_FIND, 32'h0000_0000, 16'h0000, 20'h0FFFE, 1'b1,
			'{found: 1'b1, handle: 32'hFFFF_FFFF, slot: 4'd0, byte_in_entry: 16'hFFFE,
			overwrote: 1'b0}},
		'{rlol_pkg::OP_FIND, 32'h0000_0000, 16'h0000, 20'h0FFFF, 1'b1, EMPTY_RESULT},
		'{rlol_pkg::OP_ADD,  32'h1234_5678, 16'h0001, 20'h00000, 1'b1, EMPTY_RESULT},
		'{rlol_pkg::OP_FIND, 32'h0000_0000, 16'h0000, 20'h0FFFF, 1'b0, EMPTY_RESULT},
		'{rlol_pkg::OP_FIND, 32'h0000_0000, 16'h0000, 20'h10000, 1'b0, EMPTY_RESULT},
		'{rlol_pkg::OP_ADD,  32'hA5A5_A5A5, 16'h0100, 20'h00000, 1'b0, EMPTY_RESULT},
		'{rlol_pkg::OP_ADD,  32'h5A5A_5A5A, 16'h0000, 20'h00000, 1'b0, EMPTY_RESULT},
		'{rlol_pkg::OP_ADD,  32'h0000_0001, 16'h0003, 20'h00000, 1'b0, EMPTY_RESULT},
		'{rlol_pkg::OP_ADD,  32'h8000_0000, 16'h8000, 20'h00000, 1'b0, EMPTY_RESULT},
		'{rlol_pkg::OP_ADD,  32'hDEAD_BEEF, 16'h0007, 20'h00000, 1'b0, EMPTY_RESULT},
		'{rlol_pkg::OP_ADD,  32'h0F0F_0F0F, 16'h0002, 20'h00000, 1'b0, EMPTY_RESULT},
		'{rlol_pkg::OP_ADD,  32'hF0F0_F0F0, 16'hFFFF, 20'h00000, 1'b0, EMPTY_RESULT},
		'{rlol_pkg::OP_FIND, 32'h0000_0000, 16'h0000, 20'hFFFFF, 1'b0, EMPTY_RESULT},
		'{rlol_pkg::OP_FIND, 32'h0000_0000, 16'h0000, 20'h28000, 1'b0, EMPTY_RESULT},
		'{rlol_pkg::OP_ADD,  32'h1111_1111, 16'h0005, 20'h00000, 1'b1, OVERWRITE_RESULT},
		'{rlol_pkg::OP_FIND, 32'h0000_0000, 16'h0000, 20'h00000, 1'b0, EMPTY_RESULT},
		'{rlol_pkg::OP_FIND, 32'h0000_0000, 16'h0000, 20'h00100, 1'b0, EMPTY_RESULT},
		'{rlol_pkg::OP_ADD,  32'h2222_2222, 16'h0000, 20'h00000, 1'b1, OVERWRITE_RESULT},
		'{rlol_pkg::OP_FIND, 32'h0000_0000, 16'h0000, 20'h18109, 1'b0, EMPTY_RESULT}
	};

	function automatic result_t apply_item(input opcode_t op, input logic [HANDLE_W-1:0] handle,
		input logic [SIZE_W-1:0] size, input logic [OFFSET_W-1:0] offset);
		result_t             r;
		int unsigned         cnt;
		int unsigned         idx;
		int unsigned         k;
		logic [OFFSET_W-1:0] rem;
		logic                done;
		r = '0;
		if (op == rlol_pkg::OP_ADD) begin
			r.overwrote = ring_full;
			ring_handles[ring_wr] = handle;
			ring_sizes[ring_wr] = size;
			ring_wr = (ring_wr == DEPTH - 1) ? 0 : ring_wr + 1;
			if (r.overwrote) begin
				ring_rd = ring_wr;
			end else if (ring_wr == ring_rd) begin
				ring_full = 1'b1;
			end
		end else begin
			cnt = ring_full ? DEPTH : (ring_wr + DEPTH - ring_rd) % DEPTH;
			idx = ring_rd;
			rem = offset;
			done = 1'b0;
			for (k = 0; k < cnt && !done; k++) begin
				if (ring_sizes[idx] > rem) begin
					r.found = 1'b1;
					r.handle = ring_handles[idx];
					r.slot = idx[SLOT_W-1:0];
					r.byte_in_entry = rem[SIZE_W-1:0];
					done = 1'b1;
				end else begin
					rem = rem - ring_sizes[idx];
					idx = (idx == DEPTH - 1) ? 0 : idx + 1;
				end
			end
		end
		return r;
	endfunction

	task automatic drive_item(input opcode_t op, input logic [HANDLE_W-1:0] handle,
		input logic [SIZE_W-1:0] size, input logic [OFFSET_W-1:0] offset, input logic drain,
		input logic typed, input result_t want);
		int unsigned gap;
		result_t     pred;
		gap = snd_burst ? 0 : $urandom_range(0, 12);
		if (drain && gap == 0) begin
			gap = 1;
		end
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			while (drain && expected_q.size() != 0) begin
				@(posedge clk);
			end
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.opcode <= op;
		req_if.entry_handle <= handle;
		req_if.entry_size <= size;
		req_if.byte_offset <= offset;
		do @(posedge clk); while (!req_if.ready);
		pred = apply_item(op, handle, size, offset);
		expected_q.push_back(typed ? want : pred);
		if (op == rlol_pkg::OP_ADD) begin
			add_count++;
		end else begin
			find_count++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		int unsigned         i;
		int unsigned         j;
		int unsigned         idx;
		int unsigned         cnt;
		int unsigned         total;
		int unsigned         bound;
		int unsigned         mode;
		opcode_t             op;
		logic [SIZE_W-1:0]   size;
		logic [OFFSET_W-1:0] offset;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.opcode <= rlol_pkg::OP_ADD;
		req_if.entry_handle <= '0;
		req_if.entry_size <= '0;
		req_if.byte_offset <= '0;
		for (i = 0; i < DEPTH; i++) begin
			ring_sizes[i] = '0;
			ring_handles[i] = '0;
		end
		ring_wr = 0;
		ring_rd = 0;
		ring_full = 1'b0;
		fail_count = 0;
		add_count = 0;
		find_count = 0;
		hit_count = 0;
		overwrite_count = 0;
		snd_burst = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < STEP_COUNT; i++) begin
			drive_item(steps[i].op, steps[i].handle, steps[i].size, steps[i].offset, 1'b0,
				steps[i].typed, steps[i].want);
		end

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 64 == 0) begin
				snd_burst = ($urandom_range(0, 3) == 0);
			end
			op = ($urandom_range(0, 99) < 40) ? rlol_pkg::OP_ADD : rlol_pkg::OP_FIND;
			mode = $urandom_range(0, 99);
			if (mode < 10) begin
				size = '0;
			end else if (mode < 40) begin
				size = SIZE_W'($urandom_range(1, 16));
			end else if (mode < 50) begin
				size = '1;
			end else begin
				size = SIZE_W'($urandom_range(0, 65535));
			end
			cnt = ring_full ? DEPTH : (ring_wr + DEPTH - ring_rd) % DEPTH;
			total = 0;
			idx = ring_rd;
			for (j = 0; j < cnt; j++) begin
				total += ring_sizes[idx];
				idx = (idx == DEPTH - 1) ? 0 : idx + 1;
			end
			mode = $urandom_range(0, 99);
			if (op == rlol_pkg::OP_ADD || mode >= 90 || total == 0) begin
				offset = OFFSET_W'($urandom_range(0, 20'hFFFFF));
			end else if (mode < 55) begin
				offset = OFFSET_W'($urandom_range(0, total - 1));
			end else if (mode < 80) begin
				bound = 0;
				idx = ring_rd;
				for (j = $urandom_range(0, cnt); j > 0; j--) begin
					bound += ring_sizes[idx];
					idx = (idx == DEPTH - 1) ? 0 : idx + 1;
				end
				offset = (bound == 0) ? OFFSET_W'($urandom_range(0, 1)) :
					OFFSET_W'(bound + $urandom_range(0, 2) - 1);
			end else begin
				offset = OFFSET_W'(total + $urandom_range(0, 3));
			end
			drive_item(op, $urandom(), size, offset, (i % 400 == 0), 1'b0, EMPTY_RESULT);
		end
		req_if.valid <= 1'b0;

		while (expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DEPTH + 8) @(posedge clk);
		$display("Covered %0d adds (%0d overwrote the oldest entry) and %0d finds (%0d hits).",
			add_count, overwrite_count, find_count, hit_count);
		$display("Finds ran on empty, partly filled and full rings, %s",
			"on entry boundaries and past the data.");
		if (fail_count == 0) begin
			$display("ring_log_offset_lookup_core_test OK");
		end else begin
			$display("ring_log_offset_lookup_core_test NOT OK");
		end
		$finish;
	end

	initial begin
		int unsigned stall;
		int unsigned n;
		result_t     got;
		result_t     want;
		rsp_if.ready <= 1'b0;
		rcv_burst = 1'b0;
		n = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (n % 64 == 0) begin
				rcv_burst = ($urandom_range(0, 3) == 0);
			end
			n++;
			stall = rcv_burst ? 0 : $urandom_range(0, 12);
			if (stall != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			got = '{found: rsp_if.found, handle: rsp_if.found_handle, slot: rsp_if.found_slot,
				byte_in_entry: rsp_if.byte_in_entry, overwrote: rsp_if.overwrote};
			if (got.found) begin
				hit_count++;
			end
			if (got.overwrote) begin
				overwrite_count++;
			end
			if (expected_q.size() == 0) begin
				$error("Result arrived with no item waiting for it.");
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				if (got.found !== want.found) begin
					$error("found: expected %0b, got %0b", want.found, got.found);
					fail_count++;
				end
				if (got.handle !== want.handle) begin
					$error("found_handle: expected %h, got %h", want.handle, got.handle);
					fail_count++;
				end
				if (got.slot !== want.slot) begin
					$error("found_slot: expected %0d, got %0d", want.slot, got.slot);
					fail_count++;
				end
				if (got.byte_in_entry !== want.byte_in_entry) begin
					$error("byte_in_entry: expected %h, got %h", want.byte_in_entry,
						got.byte_in_entry);
					fail_count++;
				end
				if (got.overwrote !== want.overwrote) begin
					$error("overwrote: expected %0b, got %0b", want.overwrote, got.overwrote);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("No item moved for %0d cycles.", IDLE_LIMIT);
				$display("ring_log_offset_lookup_core_test NOT OK");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

endmodule
